// ----- design/wtm_pkg.sv -----
package wtm_pkg;

    localparam int TIME_W   = 48;
    localparam int QTY_W    = 48;
    localparam int SPEED_W  = 48;
    localparam int WIN_W    = 24;
    localparam int QIN_W    = 32;
    localparam int DUR_W    = WIN_W + 1;          // summed duration before clamping
    localparam int MULH_W   = QTY_W / 2;          // half of the quantity per multiply
    localparam int MUL_W    = MULH_W + WIN_W;     // partial product
    localparam int PROD_W   = QTY_W + WIN_W;      // full dividend
    localparam int DIV_STEPS = QTY_W;             // one quotient bit a cycle
    localparam int CNT_W    = $clog2(DIV_STEPS);

    localparam logic [WIN_W-1:0] WIN_RESET   = WIN_W'(1000);
    localparam logic [WIN_W-1:0] UNITS_PER_S = WIN_W'(1000);

    localparam logic [1:0] REQ_ADD     = 2'd0;
    localparam logic [1:0] REQ_QUERY   = 2'd1;
    localparam logic [1:0] REQ_RESTART = 2'd2;

    typedef enum logic [1:0] {
        OP_SCALE_ADD,
        OP_SCALE_QRY,
        OP_SPEED_ADD,
        OP_SPEED_QRY
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_PLAN,
        ST_MUL,
        ST_SUM,
        ST_DCHK,
        ST_DIV,
        ST_POST,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]              req_type;
        logic [TIME_W-1:0]       time_ms;
        logic signed [QIN_W-1:0] quantity;
    } t_req;

    typedef struct packed {
        logic [SPEED_W-1:0] speed;
        logic [SPEED_W-1:0] last_speed;
        logic               rejected;
    } t_res;

endpackage

// ----- design/windowed_throughput_meter_top.sv -----
// Channel  | Direction | Handshake                   | Payload
// request  | in        | i_in_valid / o_in_ready     | i_in_data  (t_req: type, time, quantity)
// result   | out       | o_out_valid / i_out_ready   | o_out_data (t_res: speed, last speed, flag)
// config   | in        | i_cfg_wr_en, no wait        | i_cfg_wr_data (window length, ms)
//
// Sequence: requests that need no divide (restart, unused type, rejected add or query with no divide)
// go through PREP and PLAN straight to DONE. Each multiply-divide runs two 24x24 multiplies,
// sum, overflow check, 48 divider steps unless it saturates, write-back; a clamped add runs two.
// Reset: synchronous, active low; window back to 1000 ms, all sums and the speed to zero.
// Stalls: the result sits in an output register, so a new request is taken while it waits;
// the sequencer holds in its final state only if a second result is ready before the first goes.
module windowed_throughput_meter_top
    import wtm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [WIN_W-1:0]  i_cfg_wr_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_req              i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_res              o_out_data
);

    // architectural state
    t_state               r_state,      n_state;
    logic [WIN_W-1:0]     r_win,        n_win;
    logic [TIME_W-1:0]    r_last_tick,  n_last_tick;
    logic [WIN_W-1:0]     r_wdur,       n_wdur;
    logic [QTY_W-1:0]     r_wqty,       n_wqty;
    logic [SPEED_W-1:0]   r_stored,     n_stored;

    // request in flight
    t_req                 r_req,        n_req;
    logic [TIME_W-1:0]    r_elapsed,    n_elapsed;
    logic [SPEED_W-1:0]   r_speed,      n_speed;
    logic                 r_rej,        n_rej;

    // shared multiply-divide unit: floor(q*m/d), saturating at all ones
    t_op                  r_op,         n_op;
    logic [QTY_W-1:0]     r_mq,         n_mq;
    logic [WIN_W-1:0]     r_mm,         n_mm;
    logic [DUR_W-1:0]     r_md,         n_md;
    logic                 r_mstep,      n_mstep;
    logic [MUL_W-1:0]     r_plo,        n_plo;
    logic [MUL_W-1:0]     r_phi,        n_phi;
    logic [PROD_W-1:0]    r_prod,       n_prod;
    logic [DUR_W-1:0]     r_rem,        n_rem;
    logic [QTY_W-1:0]     r_quo,        n_quo;
    logic [CNT_W-1:0]     r_cnt,        n_cnt;

    // result register
    t_res                 r_out,        n_out;
    logic                 r_out_valid,  n_out_valid;

    // start request for the unit
    logic                 go;
    logic [QTY_W-1:0]     go_q;
    logic [WIN_W-1:0]     go_m;
    logic [DUR_W-1:0]     go_d;
    t_op                  go_op;

    // datapath helpers
    logic [QTY_W-1:0]     qin_ext;
    logic [QTY_W:0]       qsum;
    logic [QTY_W-1:0]     nq_sat;
    logic [DUR_W-1:0]     dsum;
    logic                 win_nz;
    logic                 gap;
    logic                 over;
    logic                 wz_active;
    logic [MULH_W-1:0]    mul_a;
    logic [MUL_W-1:0]     mul_out;
    logic [DUR_W:0]       div_shift;
    logic [DUR_W+1:0]     div_diff;
    logic [DUR_W-1:0]     prod_top;

    assign qin_ext   = QTY_W'(r_req.quantity[QIN_W-2:0]);
    assign qsum      = {1'b0, r_wqty} + {1'b0, qin_ext};
    assign nq_sat    = qsum[QTY_W] ? '1 : qsum[QTY_W-1:0];
    // only meaningful when the gap is below the window, so the low bits of elapsed suffice
    assign dsum      = DUR_W'(r_wdur) + DUR_W'(r_elapsed[WIN_W-1:0]);
    assign win_nz    = (r_win != '0);
    assign gap       = (r_elapsed >= TIME_W'(r_win));
    assign over      = (dsum > DUR_W'(r_win));
    assign wz_active = (r_wdur != '0) || (r_elapsed != '0);

    assign mul_a     = r_mstep ? r_mq[QTY_W-1:MULH_W] : r_mq[MULH_W-1:0];
    assign mul_out   = MUL_W'(mul_a) * MUL_W'(r_mm);

    // restoring divider step: remainder stays below d, so one subtract decides the bit
    assign div_shift = {r_rem, r_quo[QTY_W-1]};
    assign div_diff  = {1'b0, div_shift} - (DUR_W+2)'(r_md);
    assign prod_top  = DUR_W'(r_prod[PROD_W-1:QTY_W]);

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_win       <= WIN_RESET;
            r_last_tick <= '0;
            r_wdur      <= '0;
            r_wqty      <= '0;
            r_stored    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_win       <= n_win;
            r_last_tick <= n_last_tick;
            r_wdur      <= n_wdur;
            r_wqty      <= n_wqty;
            r_stored    <= n_stored;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_elapsed <= n_elapsed;
        r_speed   <= n_speed;
        r_rej     <= n_rej;
        r_op      <= n_op;
        r_mq      <= n_mq;
        r_mm      <= n_mm;
        r_md      <= n_md;
        r_mstep   <= n_mstep;
        r_plo     <= n_plo;
        r_phi     <= n_phi;
        r_prod    <= n_prod;
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_cnt     <= n_cnt;
        r_out     <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_win       = r_win;
        n_last_tick = r_last_tick;
        n_wdur      = r_wdur;
        n_wqty      = r_wqty;
        n_stored    = r_stored;
        n_req       = r_req;
        n_elapsed   = r_elapsed;
        n_speed     = r_speed;
        n_rej       = r_rej;
        n_op        = r_op;
        n_mq        = r_mq;
        n_mm        = r_mm;
        n_md        = r_md;
        n_mstep     = r_mstep;
        n_plo       = r_plo;
        n_phi       = r_phi;
        n_prod      = r_prod;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_cnt       = r_cnt;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;

        go    = 1'b0;
        go_q  = '0;
        go_m  = '0;
        go_d  = '0;
        go_op = OP_SPEED_ADD;

        if (i_cfg_wr_en) begin
            n_win = i_cfg_wr_data;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_req   = i_in_data;
                    n_state = ST_PREP;
                end
            end

            ST_PREP: begin
                // time running backwards still counts as elapsed
                n_elapsed = (r_req.time_ms >= r_last_tick) ? r_req.time_ms - r_last_tick
                                                           : r_last_tick - r_req.time_ms;
                n_state   = ST_PLAN;
            end

            ST_PLAN: begin
                n_speed = '0;
                n_rej   = 1'b0;
                n_state = ST_DONE;
                case (r_req.req_type)
                    REQ_ADD: begin
                        if (r_req.quantity[QIN_W-1]) begin
                            n_rej = 1'b1;
                        end else if (win_nz && gap) begin
                            // gap covers the whole window: start afresh
                            n_last_tick = r_req.time_ms;
                            n_wdur      = r_win;
                            n_wqty      = qin_ext;
                            go          = 1'b1;
                            go_q        = qin_ext;
                            go_m        = UNITS_PER_S;
                            go_d        = DUR_W'(r_win);
                            go_op       = OP_SPEED_ADD;
                        end else if (!win_nz) begin
                            // zero window: sums collapse once any time has passed
                            n_last_tick = r_req.time_ms;
                            n_wdur      = '0;
                            n_wqty      = wz_active ? '0 : nq_sat;
                            n_speed     = r_stored;
                        end else begin
                            n_last_tick = r_req.time_ms;
                            if (over) begin
                                go    = 1'b1;
                                go_q  = nq_sat;
                                go_m  = r_win;
                                go_d  = dsum;
                                go_op = OP_SCALE_ADD;
                            end else begin
                                n_wdur = dsum[WIN_W-1:0];
                                n_wqty = nq_sat;
                                if (dsum != '0) begin
                                    go    = 1'b1;
                                    go_q  = nq_sat;
                                    go_m  = UNITS_PER_S;
                                    go_d  = dsum;
                                    go_op = OP_SPEED_ADD;
                                end else begin
                                    n_speed = r_stored;
                                end
                            end
                        end
                    end
                    REQ_QUERY: begin
                        if (win_nz && !gap) begin
                            if (over) begin
                                go    = 1'b1;
                                go_q  = r_wqty;
                                go_m  = r_win;
                                go_d  = dsum;
                                go_op = OP_SCALE_QRY;
                            end else if (dsum != '0) begin
                                go    = 1'b1;
                                go_q  = r_wqty;
                                go_m  = UNITS_PER_S;
                                go_d  = dsum;
                                go_op = OP_SPEED_QRY;
                            end
                        end
                    end
                    REQ_RESTART: begin
                        n_last_tick = r_req.time_ms;
                        n_wdur      = '0;
                        n_wqty      = '0;
                        n_stored    = '0;
                    end
                    default: begin
                    end
                endcase
            end

            ST_MUL: begin
                n_mstep = 1'b1;
                if (!r_mstep) begin
                    n_plo = mul_out;
                end else begin
                    n_phi   = mul_out;
                    n_state = ST_SUM;
                end
            end

            ST_SUM: begin
                n_prod  = {r_phi, MULH_W'(0)} + PROD_W'(r_plo);
                n_state = ST_DCHK;
            end

            ST_DCHK: begin
                // quotient needs more than QTY_W bits: saturate
                if (prod_top >= r_md) begin
                    n_quo   = '1;
                    n_state = ST_POST;
                end else begin
                    n_rem   = prod_top;
                    n_quo   = r_prod[QTY_W-1:0];
                    n_cnt   = '0;
                    n_state = ST_DIV;
                end
            end

            ST_DIV: begin
                if (!div_diff[DUR_W+1]) begin
                    n_rem = div_diff[DUR_W-1:0];
                    n_quo = {r_quo[QTY_W-2:0], 1'b1};
                end else begin
                    n_rem = div_shift[DUR_W-1:0];
                    n_quo = {r_quo[QTY_W-2:0], 1'b0};
                end
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_POST;
                end
            end

            ST_POST: begin
                case (r_op)
                    OP_SCALE_ADD: begin
                        n_wqty = r_quo;
                        n_wdur = r_win;
                        go     = 1'b1;
                        go_q   = r_quo;
                        go_m   = UNITS_PER_S;
                        go_d   = DUR_W'(r_win);
                        go_op  = OP_SPEED_ADD;
                    end
                    OP_SCALE_QRY: begin
                        go    = 1'b1;
                        go_q  = r_quo;
                        go_m  = UNITS_PER_S;
                        go_d  = DUR_W'(r_win);
                        go_op = OP_SPEED_QRY;
                    end
                    OP_SPEED_ADD: begin
                        n_stored = r_quo;
                        n_speed  = r_quo;
                        n_state  = ST_DONE;
                    end
                    default: begin
                        n_speed = r_quo;
                        n_state = ST_DONE;
                    end
                endcase
            end

            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out.speed      = r_speed;
                    n_out.last_speed = r_stored;
                    n_out.rejected   = r_rej;
                    n_out_valid      = 1'b1;
                    n_state          = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (go) begin
            n_mq    = go_q;
            n_mm    = go_m;
            n_md    = go_d;
            n_op    = go_op;
            n_mstep = 1'b0;
            n_state = ST_MUL;
        end
    end

endmodule

// ----- design/wtm_checker.sv -----
module wtm_checker
    import wtm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              o_in_ready,
    input  logic              o_out_valid,
    input  logic              i_out_ready,
    input  t_res              o_out_data
);

    // busy once a request has been taken
    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request taken while previous one still in progress");

    // a new result only comes from a request being worked on
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result appeared with no request in progress");

    // a rejected add reports no speed
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.rejected) |-> (o_out_data.speed == '0))
        else $error("rejected request reports nonzero speed");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result dropped or changed");

endmodule

bind windowed_throughput_meter_top wtm_checker u_wtm_checker (.*);
